// ===== design/rhc_pkg.sv =====
package rhc_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int HUE_FRAC_BITS = 6;

  localparam int HUE_W = 15;
  localparam int FRAC_W = 16;

  localparam longint unsigned CH_MAX = (64'd1 << CHANNEL_BITS) - 64'd1;
  localparam longint unsigned FRAC_MAX = 64'd65535;
  localparam longint unsigned HUE_UNIT = 64'd60 << HUE_FRAC_BITS;
  localparam longint unsigned HUE_LIMIT = 64'd360 << HUE_FRAC_BITS;

  localparam longint unsigned HUE_NUM_MAX = HUE_UNIT * 64'd6 * CH_MAX;
  localparam longint unsigned SAT_NUM_MAX = CH_MAX * FRAC_MAX;

  localparam int HUE_NUM_W = $clog2(HUE_NUM_MAX + 64'd1);
  localparam int SAT_NUM_W = $clog2(SAT_NUM_MAX + 64'd1);
  localparam int DIV_W = (HUE_NUM_W > SAT_NUM_W) ? HUE_NUM_W : SAT_NUM_W;

  localparam int DEN_W = CHANNEL_BITS + 1;
  localparam int SUM_W = CHANNEL_BITS + 1;
  localparam int M_W = $clog2(64'd6 * CH_MAX + 64'd1);

  // Lightness is sum * FRAC_MAX / (2 * CH_MAX), taken as a multiply by a rounded-up
  // reciprocal. The shift keeps sum * divisor below 2^LIGHT_SHIFT, so it is exact.
  localparam int LIGHT_SHIFT = 2 * SUM_W;
  localparam longint unsigned LIGHT_RECIP =
    ((FRAC_MAX << LIGHT_SHIFT) + 64'd2 * CH_MAX - 64'd1) / (64'd2 * CH_MAX);
  localparam int LIGHT_RECIP_W = $clog2(LIGHT_RECIP + 64'd1);
  localparam int LIGHT_PROD_W = SUM_W + LIGHT_RECIP_W;

  localparam int HUE_Q_W = $clog2(HUE_LIMIT);
  localparam int HUE_QK_W = (HUE_Q_W > HUE_W) ? HUE_Q_W : HUE_W;

  localparam int NUM_STAGES = DIV_W + 3;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [M_W-1:0]          m;
    logic [CHANNEL_BITS-1:0] chroma;
    logic [SUM_W-1:0]        sum;
    logic [CHANNEL_BITS-1:0] sat_den;
    logic                    grey;
    logic                    sat_zero;
  } pre_t;

  typedef struct packed {
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
  } lane_t;

  typedef struct packed {
    lane_t                hue_l;
    lane_t                sat_l;
    logic [HUE_QK_W-1:0]  q_hue;
    logic [FRAC_W-1:0]    q_sat;
    logic [FRAC_W-1:0]    q_light;
    logic                 grey;
    logic                 sat_zero;
  } div_t;

endpackage

// ===== design/rhc_pixel_if.sv =====
interface rhc_pixel_if
  import rhc_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== design/rhc_hsl_if.sv =====
interface rhc_hsl_if
  import rhc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [HUE_W-1:0]  hue;
  logic [FRAC_W-1:0] saturation;
  logic [FRAC_W-1:0] lightness;

  modport source (output valid, output hue, output saturation, output lightness, input ready);
  modport sink (input valid, input hue, input saturation, input lightness, output ready);
endinterface

// ===== design/rhc_div_step.sv =====
module rhc_div_step
  import rhc_pkg::*;
(
  input  lane_t lane_in,
  output lane_t lane_out,
  output logic  qbit
);

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;

  always_comb begin
    trial = {lane_in.rem, lane_in.num[DIV_W-1]};
    diff = trial - {1'b0, lane_in.den};
    qbit = (trial >= {1'b0, lane_in.den});
    lane_out.den = lane_in.den;
    lane_out.num = {lane_in.num[DIV_W-2:0], 1'b0};
    lane_out.rem = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

endmodule

// ===== design/rgb_to_hsl_converter.sv =====
// Throughput: one pixel per clock while the output is not stalled; each divider stage
// resolves one quotient bit for the hue and saturation lanes side by side, so the
// pipeline depth follows DIV_W. Lightness comes from a reciprocal multiply and rides
// along with the divider stages. A one-beat skid register at the output keeps the input
// open when a stall first appears. Reset (synchronous, active high) clears the stage
// valid bits and the skid register's valid bit.
module rgb_to_hsl_converter
  import rhc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  rhc_pixel_if.sink    pixel,
  rhc_hsl_if.source    hsl
);

  logic [NUM_STAGES-1:0] vld;
  logic                  en;

  pix_t pix;
  pre_t pre;
  pre_t pre_next;
  div_t d [DIV_W+1];
  div_t d0_next;

  logic [LIGHT_PROD_W-1:0] light_prod;

  logic              skid_vld;
  logic [HUE_W-1:0]  skid_hue;
  logic [FRAC_W-1:0] skid_sat;
  logic [FRAC_W-1:0] skid_light;
  logic [HUE_W-1:0]  hue_o;
  logic [FRAC_W-1:0] sat_o;
  logic [FRAC_W-1:0] light_o;

  assign en = !skid_vld;
  assign pixel.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_STAGES-2:0], pixel.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix.red <= pixel.red;
      pix.green <= pixel.green;
      pix.blue <= pixel.blue;
    end
  end

  logic [CHANNEL_BITS-1:0] hi;
  logic [CHANNEL_BITS-1:0] lo;
  logic [M_W-1:0]          c_m;
  logic [SUM_W-1:0]        dev;
  logic [SUM_W-1:0]        fs_s;

  always_comb begin
    hi = pix.red;
    lo = pix.red;
    if (pix.green > hi) hi = pix.green;
    if (pix.blue > hi) hi = pix.blue;
    if (pix.green < lo) lo = pix.green;
    if (pix.blue < lo) lo = pix.blue;
    pre_next.chroma = hi - lo;
    pre_next.sum = SUM_W'(hi) + SUM_W'(lo);
    c_m = M_W'(pre_next.chroma);
    // The hue sector offset is folded in here; the result never goes negative.
    if (hi == pix.red) begin
      if (pix.green >= pix.blue) begin
        pre_next.m = M_W'(pix.green) - M_W'(pix.blue);
      end else begin
        pre_next.m = M_W'(6) * c_m + M_W'(pix.green) - M_W'(pix.blue);
      end
    end else if (hi == pix.green) begin
      pre_next.m = M_W'(2) * c_m + M_W'(pix.blue) - M_W'(pix.red);
    end else begin
      pre_next.m = M_W'(4) * c_m + M_W'(pix.red) - M_W'(pix.green);
    end
    fs_s = SUM_W'(CH_MAX);
    dev = (pre_next.sum >= fs_s) ? (pre_next.sum - fs_s) : (fs_s - pre_next.sum);
    pre_next.sat_den = CHANNEL_BITS'(fs_s - dev);
    pre_next.grey = (pre_next.chroma == '0);
    pre_next.sat_zero = (pre_next.sum == '0) || (pre_next.sum == SUM_W'(64'd2 * CH_MAX));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre <= pre_next;
    end
  end

  always_comb begin
    light_prod = LIGHT_PROD_W'(pre.sum) * LIGHT_PROD_W'(LIGHT_RECIP);
    d0_next.hue_l.num = DIV_W'(pre.m) * DIV_W'(HUE_UNIT);
    d0_next.hue_l.den = DEN_W'(pre.chroma);
    d0_next.hue_l.rem = '0;
    d0_next.sat_l.num = DIV_W'(pre.chroma) * DIV_W'(FRAC_MAX);
    d0_next.sat_l.den = DEN_W'(pre.sat_den);
    d0_next.sat_l.rem = '0;
    d0_next.q_hue = '0;
    d0_next.q_sat = '0;
    d0_next.q_light = FRAC_W'(light_prod >> LIGHT_SHIFT);
    d0_next.grey = pre.grey;
    d0_next.sat_zero = pre.sat_zero;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d[0] <= d0_next;
    end
  end

  for (genvar j = 0; j < DIV_W; j++) begin : g_div
    div_t step_next;
    logic qh;
    logic qs;

    rhc_div_step u_hue (.lane_in(d[j].hue_l), .lane_out(step_next.hue_l), .qbit(qh));
    rhc_div_step u_sat (.lane_in(d[j].sat_l), .lane_out(step_next.sat_l), .qbit(qs));

    assign step_next.q_hue = {d[j].q_hue[HUE_QK_W-2:0], qh};
    assign step_next.q_sat = {d[j].q_sat[FRAC_W-2:0], qs};
    assign step_next.q_light = d[j].q_light;
    assign step_next.grey = d[j].grey;
    assign step_next.sat_zero = d[j].sat_zero;

    always_ff @(posedge clk) begin
      if (en) begin
        d[j+1] <= step_next;
      end
    end
  end

  always_comb begin
    hue_o = d[DIV_W].grey ? '0 : d[DIV_W].q_hue[HUE_W-1:0];
    sat_o = d[DIV_W].sat_zero ? '0 : d[DIV_W].q_sat;
    light_o = d[DIV_W].q_light;
  end

  // The skid register takes the last stage's beat when the sink stalls, and the
  // pipeline holds until that beat is gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_vld <= 1'b0;
    end else if (skid_vld) begin
      if (hsl.ready) skid_vld <= 1'b0;
    end else if (vld[NUM_STAGES-1] && !hsl.ready) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld) begin
      skid_hue <= hue_o;
      skid_sat <= sat_o;
      skid_light <= light_o;
    end
  end

  assign hsl.valid = skid_vld || vld[NUM_STAGES-1];
  assign hsl.hue = skid_vld ? skid_hue : hue_o;
  assign hsl.saturation = skid_vld ? skid_sat : sat_o;
  assign hsl.lightness = skid_vld ? skid_light : light_o;

`ifndef NO_ASSERTIONS
  a_enter: assert property (@(posedge clk) disable iff (rst)
    pixel.valid && pixel.ready |=> vld[0])
    else $error("accepted pixel did not enter the pipeline");

  a_hue_rem: assert property (@(posedge clk) disable iff (rst)
    vld[NUM_STAGES-1] && !d[DIV_W].grey |-> d[DIV_W].hue_l.rem < d[DIV_W].hue_l.den)
    else $error("hue divider remainder not below divisor");

  a_skid_catch: assert property (@(posedge clk) disable iff (rst)
    !skid_vld && vld[NUM_STAGES-1] && !hsl.ready |=> skid_vld)
    else $error("stalled result was not captured by the skid register");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsl.valid && (HUE_Q_W <= HUE_W) |-> hsl.hue < HUE_W'(HUE_LIMIT))
    else $error("hue out of range");
`endif

endmodule

// ===== verif/tb.sv =====
module tb;
  import rhc_pkg::*;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [FRAC_W-1:0] saturation;
    logic [FRAC_W-1:0] lightness;
  } hsl_t;

  typedef struct {
    pix_t pix;
    bit   drain_first;
  } pixel_job_t;

  localparam int DIRECTED_PIXELS = 22;
  localparam int RANDOM_PIXELS = 1280;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 40;

  logic clk;
  logic rst;

  rhc_pixel_if pixel_bus ();
  rhc_hsl_if   hsl_bus ();

  rgb_to_hsl_converter i_dut (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel_bus),
    .hsl   (hsl_bus)
  );

  pixel_job_t pixel_queue[$];
  hsl_t       hsl_expected[$];
  hsl_t       want_hsl;
  hsl_t       got_hsl;

  int  total_pixels = 0;
  int  pixels_sent = 0;
  int  results_checked = 0;
  int  grey_pixels = 0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  int  idle_left = 0;
  int  stall_left = 0;
  bit  pix_taken = 1'b0;

  function automatic hsl_t hsl_of(pix_t p);
    longint unsigned r, g, b, hi, lo, chroma, sum, num, hue_val, dev, sat_val, light_val;
    hsl_t res;
    r = p.red;
    g = p.green;
    b = p.blue;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    chroma = hi - lo;
    sum = hi + lo;
    if (chroma == 0) begin
      hue_val = 0;
    end else begin
      if (hi == r) begin
        if (g >= b) num = HUE_UNIT * (g - b);
        else num = HUE_UNIT * 6 * chroma - HUE_UNIT * (b - g);
      end else if (hi == g) begin
        if (b >= r) num = HUE_UNIT * 2 * chroma + HUE_UNIT * (b - r);
        else num = HUE_UNIT * 2 * chroma - HUE_UNIT * (r - b);
      end else begin
        if (r >= g) num = HUE_UNIT * 4 * chroma + HUE_UNIT * (r - g);
        else num = HUE_UNIT * 4 * chroma - HUE_UNIT * (g - r);
      end
      hue_val = num / chroma;
    end
    light_val = (sum * FRAC_MAX) / (2 * CH_MAX);
    if (sum == 0 || sum == 2 * CH_MAX) begin
      sat_val = 0;
    end else begin
      dev = (sum >= CH_MAX) ? (sum - CH_MAX) : (CH_MAX - sum);
      sat_val = (chroma * FRAC_MAX) / (CH_MAX - dev);
      if (sat_val > FRAC_MAX) sat_val = FRAC_MAX;
    end
    res.hue = hue_val[HUE_W-1:0];
    res.saturation = sat_val[FRAC_W-1:0];
    res.lightness = light_val[FRAC_W-1:0];
    return res;
  endfunction

  function automatic bit in_quiet_stretch();
    return (pixel_queue.size() < 200) ||
           (pixel_queue.size() >= 600 && pixel_queue.size() < 700);
  endfunction

  function automatic logic [CHANNEL_BITS-1:0] near_value(int base);
    int v;
    v = base + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > int'(CH_MAX)) v = int'(CH_MAX);
    return v[CHANNEL_BITS-1:0];
  endfunction

  task automatic add_pixel(int r, int g, int b, bit drain_first);
    pixel_job_t job;
    job.pix.red = r[CHANNEL_BITS-1:0];
    job.pix.green = g[CHANNEL_BITS-1:0];
    job.pix.blue = b[CHANNEL_BITS-1:0];
    job.drain_first = drain_first;
    pixel_queue.push_back(job);
    total_pixels++;
  endtask

  task automatic add_random_pixel(bit drain_first);
    int mode;
    int base;
    int r, g, b;
    mode = $urandom_range(0, 9);
    base = $urandom_range(0, int'(CH_MAX));
    r = $urandom_range(0, int'(CH_MAX));
    g = $urandom_range(0, int'(CH_MAX));
    b = $urandom_range(0, int'(CH_MAX));
    case (mode)
      6, 7: begin
        r = near_value(base);
        g = near_value(base);
        b = near_value(base);
      end
      8: begin
        case ($urandom_range(0, 2))
          0: g = r;
          1: b = g;
          default: b = r;
        endcase
      end
      9: begin
        r = ($urandom_range(0, 1) != 0) ? int'(CH_MAX) - $urandom_range(0, 1)
                                        : $urandom_range(0, 1);
        g = ($urandom_range(0, 1) != 0) ? int'(CH_MAX) - $urandom_range(0, 1)
                                        : $urandom_range(0, 1);
        b = ($urandom_range(0, 1) != 0) ? int'(CH_MAX) - $urandom_range(0, 1)
                                        : $urandom_range(0, 1);
      end
      default: begin
      end
    endcase
    add_pixel(r, g, b, drain_first);
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    pixel_bus.valid = 1'b0;
    pixel_bus.red = '0;
    pixel_bus.green = '0;
    pixel_bus.blue = '0;
    hsl_bus.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    if (rst) begin
      pixel_bus.valid <= 1'b0;
    end else if (!pixel_bus.valid || pix_taken) begin
      if (idle_left > 0) begin
        pixel_bus.valid <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (pixel_queue.size() == 0) begin
        pixel_bus.valid <= 1'b0;
      end else if (pixel_queue[0].drain_first && hsl_expected.size() != 0) begin
        pixel_bus.valid <= 1'b0;
      end else begin
        pixel_bus.red <= pixel_queue[0].pix.red;
        pixel_bus.green <= pixel_queue[0].pix.green;
        pixel_bus.blue <= pixel_queue[0].pix.blue;
        pixel_bus.valid <= 1'b1;
        void'(pixel_queue.pop_front());
        if (!in_quiet_stretch() && $urandom_range(0, 4) == 0) begin
          idle_left <= $urandom_range(1, 7);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      hsl_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      hsl_bus.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!in_quiet_stretch() && $urandom_range(0, 7) == 0) begin
      hsl_bus.ready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      hsl_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pix_taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      pix_taken <= pixel_bus.valid && pixel_bus.ready;
      if (hsl_bus.valid && hsl_bus.ready) begin
        got_hsl.hue = hsl_bus.hue;
        got_hsl.saturation = hsl_bus.saturation;
        got_hsl.lightness = hsl_bus.lightness;
        if (hsl_expected.size() == 0) begin
          $display("%0t: unexpected result hue=%0d sat=%0d light=%0d", $time,
                   got_hsl.hue, got_hsl.saturation, got_hsl.lightness);
          mismatches++;
        end else begin
          want_hsl = hsl_expected.pop_front();
          if (got_hsl.hue !== want_hsl.hue) begin
            $display("%0t: hue expected %0d actual %0d", $time, want_hsl.hue, got_hsl.hue);
            mismatches++;
          end
          if (got_hsl.saturation !== want_hsl.saturation) begin
            $display("%0t: saturation expected %0d actual %0d", $time,
                     want_hsl.saturation, got_hsl.saturation);
            mismatches++;
          end
          if (got_hsl.lightness !== want_hsl.lightness) begin
            $display("%0t: lightness expected %0d actual %0d", $time,
                     want_hsl.lightness, got_hsl.lightness);
            mismatches++;
          end
        end
        results_checked++;
      end
      if (pixel_bus.valid && pixel_bus.ready) begin
        hsl_expected.push_back(hsl_of('{red: pixel_bus.red, green: pixel_bus.green,
                                        blue: pixel_bus.blue}));
        if (pixel_bus.red == pixel_bus.green && pixel_bus.green == pixel_bus.blue) begin
          grey_pixels++;
        end
        pixels_sent++;
      end
      if ((pixel_bus.valid && pixel_bus.ready) || (hsl_bus.valid && hsl_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    add_pixel(0, 0, 0, 1'b0);
    add_pixel(255, 255, 255, 1'b0);
    add_pixel(128, 128, 128, 1'b0);
    add_pixel(255, 0, 0, 1'b0);
    add_pixel(0, 255, 0, 1'b0);
    add_pixel(0, 0, 255, 1'b0);
    add_pixel(255, 255, 0, 1'b0);
    add_pixel(0, 255, 255, 1'b0);
    add_pixel(255, 0, 255, 1'b0);
    add_pixel(255, 0, 1, 1'b0);
    add_pixel(255, 1, 0, 1'b0);
    add_pixel(1, 255, 0, 1'b0);
    add_pixel(0, 255, 1, 1'b0);
    add_pixel(1, 0, 255, 1'b0);
    add_pixel(0, 1, 255, 1'b0);
    add_pixel(1, 0, 0, 1'b0);
    add_pixel(254, 255, 254, 1'b0);
    add_pixel(255, 254, 255, 1'b0);
    add_pixel(127, 128, 127, 1'b0);
    add_pixel(128, 127, 127, 1'b0);
    add_pixel(170, 85, 170, 1'b0);
    add_pixel(85, 170, 85, 1'b0);
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      add_random_pixel(i == 0 || i == RANDOM_PIXELS / 2);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pixels_sent < total_pixels) @(posedge clk);
    while (hsl_expected.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Converted %0d pixels (%0d directed, %0d grey) and checked %0d results.",
             pixels_sent, DIRECTED_PIXELS, grey_pixels, results_checked);
    $display("Both sides saw random idle bursts, drained pauses and idle-free stretches.");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== rgb_to_hsl_converter.f =====
design/rhc_pkg.sv
design/rhc_pixel_if.sv
design/rhc_hsl_if.sv
design/rhc_div_step.sv
design/rgb_to_hsl_converter.sv
verif/tb.sv
